// File: rtl/facp_pkg.sv
// Shared types, character codes, command codes and parse functions of the command parser.
`default_nettype none
package facp_pkg;

    localparam int PAYLOAD_STORE_SIZE = 64;
    localparam int COUNT_W = $clog2(PAYLOAD_STORE_SIZE);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(PAYLOAD_STORE_SIZE - 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_T      = 8'h54;

    localparam logic [3:0] CMD_INVALID  = 4'd0;
    localparam logic [3:0] CMD_PING     = 4'd1;
    localparam logic [3:0] CMD_STOP     = 4'd2;
    localparam logic [3:0] CMD_FORWARD  = 4'd3;
    localparam logic [3:0] CMD_BACKWARD = 4'd4;
    localparam logic [3:0] CMD_LEFT     = 4'd5;
    localparam logic [3:0] CMD_RIGHT    = 4'd6;
    localparam logic [3:0] CMD_MOVE     = 4'd7;
    localparam logic [3:0] CMD_TIMEOUT  = 4'd8;

    localparam logic [1:0] FIELD_CMD  = 2'd0;
    localparam logic [1:0] FIELD_ARG1 = 2'd1;
    localparam logic [1:0] FIELD_ARG2 = 2'd2;
    localparam logic [1:0] FIELD_REST = 2'd3;

    typedef enum logic [3:0] {
        NUM_SKIP   = 4'b0001,
        NUM_SIGN   = 4'b0010,
        NUM_DIGITS = 4'b0100,
        NUM_DONE   = 4'b1000
    } t_num_phase;

    typedef struct packed {
        logic [15:0] acc;
        t_num_phase  phase;
        logic        neg;
    } t_num_state;

    typedef struct packed {
        logic               valid;
        logic [3:0]         code;
        logic signed [15:0] first;
        logic signed [15:0] second;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic t_num_state num_step(input t_num_state s, input logic [7:0] b);
        t_num_state r;
        r = s;
        case (s.phase)
            NUM_SKIP: begin
                if (is_space(b)) begin
                    r = s;
                end else if (b == CH_PLUS || b == CH_MINUS) begin
                    r.neg   = (b == CH_MINUS);
                    r.phase = NUM_SIGN;
                end else if (is_digit(b)) begin
                    r.phase = NUM_DIGITS;
                    r.acc   = 16'({s.acc[12:0], 3'b000}) + 16'({s.acc[14:0], 1'b0})
                              + {12'd0, b[3:0]};
                end else begin
                    r.phase = NUM_DONE;
                end
            end
            NUM_SIGN, NUM_DIGITS: begin
                if (is_digit(b)) begin
                    r.phase = NUM_DIGITS;
                    r.acc   = 16'({s.acc[12:0], 3'b000}) + 16'({s.acc[14:0], 1'b0})
                              + {12'd0, b[3:0]};
                end else begin
                    r.phase = NUM_DONE;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] letter_code(input logic [7:0] c);
        logic [3:0] code;
        case (c)
            CH_P:    code = CMD_PING;
            CH_S:    code = CMD_STOP;
            CH_F:    code = CMD_FORWARD;
            CH_B:    code = CMD_BACKWARD;
            CH_L:    code = CMD_LEFT;
            CH_R:    code = CMD_RIGHT;
            CH_M:    code = CMD_MOVE;
            CH_T:    code = CMD_TIMEOUT;
            default: code = CMD_INVALID;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// File: rtl/facp_if.sv
// Valid/ready channel interfaces for received bytes and decoded commands.
`default_nettype none
interface facp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface facp_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         command_code;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;

    modport source (output valid, output command_code, output first_value,
                    output second_value, input ready);
    modport sink   (input valid, input command_code, input first_value,
                    input second_value, output ready);
endinterface
`default_nettype wire

// File: rtl/framed_ascii_command_parser_core.sv
// Top level of the framed ASCII command parser: input register, parse state, result register.
// Takes one received byte per cycle on i_rx while no command waits on o_cmd, and returns one
// decoded command on o_cmd for each frame closed by '}' or cut off by payload overflow. Bytes
// can follow back to back while o_cmd is free. A command passes through the input register,
// the frame update and the result register before it is shown on o_cmd. The input register and
// the result register stand on either side of the update of the frame and number state. While
// a command waits on o_cmd the parse state holds; the input register takes at most one more
// byte, and i_rx then stalls until the command is taken.
`default_nettype none
module framed_ascii_command_parser_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    facp_byte_if.sink    i_rx,
    facp_cmd_if.source   o_cmd
);
    import facp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       adv;
    t_result    result;

    assign adv        = !r_out_valid || o_cmd.ready;
    assign i_rx.ready = !r_in_valid || adv;

    facp_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && adv),
        .i_byte   (r_in_byte),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_rx.ready) begin
                r_in_valid <= i_rx.valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid && result.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        if (adv && r_in_valid && result.valid) begin
            r_out <= result;
        end
    end

    assign o_cmd.valid        = r_out_valid;
    assign o_cmd.command_code = r_out.code;
    assign o_cmd.first_value  = r_out.first;
    assign o_cmd.second_value = r_out.second;

endmodule
`default_nettype wire

// File: rtl/facp_frame.sv
// Frame, field and number parsing state with its update logic.
`default_nettype none
module facp_frame (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire logic [7:0]     i_byte,
    output facp_pkg::t_result   o_result
);
    import facp_pkg::*;

    logic               r_frame_open, n_frame_open;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [1:0]         r_field, n_field;
    logic               r_inside, n_inside;
    logic               r_text_ended, n_text_ended;
    logic [7:0]         r_letter, n_letter;
    t_num_phase         r_phase, n_phase;
    logic               r_neg, n_neg;
    logic [15:0]        r_acc1, n_acc1;
    logic [15:0]        r_acc2, n_acc2;

    logic [15:0] fin_acc1;
    logic [15:0] fin_acc2;
    logic [3:0]  code;
    t_num_state  num_in;
    t_num_state  num_out;

    always_comb begin
        fin_acc1 = (r_inside && r_neg && r_field == FIELD_ARG1) ? 16'(16'd0 - r_acc1) : r_acc1;
        fin_acc2 = (r_inside && r_neg && r_field == FIELD_ARG2) ? 16'(16'd0 - r_acc2) : r_acc2;
        code     = letter_code(r_letter);
        num_in.acc   = (r_field == FIELD_ARG1) ? r_acc1 : r_acc2;
        num_in.phase = r_inside ? r_phase : NUM_SKIP;
        num_in.neg   = r_inside ? r_neg : 1'b0;
        num_out      = num_step(num_in, i_byte);
    end

    always_comb begin
        n_frame_open = r_frame_open;
        n_count      = r_count;
        n_field      = r_field;
        n_inside     = r_inside;
        n_text_ended = r_text_ended;
        n_letter     = r_letter;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_acc1       = r_acc1;
        n_acc2       = r_acc2;
        o_result     = '{valid: 1'b0, code: CMD_INVALID, first: 16'sd0, second: 16'sd0};

        if (i_step && (i_byte == CH_LBRACE || (r_frame_open && i_byte == CH_RBRACE)
                       || (r_frame_open && r_count == COUNT_LAST))) begin
            if (i_byte == CH_RBRACE && i_byte != CH_LBRACE) begin
                o_result.valid = 1'b1;
                o_result.code  = code;
                case (code)
                    CMD_FORWARD, CMD_BACKWARD, CMD_LEFT, CMD_RIGHT, CMD_TIMEOUT: begin
                        o_result.first = fin_acc1;
                    end
                    CMD_MOVE: begin
                        o_result.first  = fin_acc1;
                        o_result.second = fin_acc2;
                    end
                    default: begin
                        o_result.first = 16'sd0;
                    end
                endcase
            end else if (i_byte != CH_LBRACE) begin
                o_result.valid = 1'b1;
            end
            n_frame_open = (i_byte == CH_LBRACE);
            n_count      = '0;
            n_field      = FIELD_CMD;
            n_inside     = 1'b0;
            n_text_ended = 1'b0;
            n_letter     = CH_NUL;
            n_phase      = NUM_SKIP;
            n_neg        = 1'b0;
            n_acc1       = '0;
            n_acc2       = '0;
        end else if (i_step && r_frame_open) begin
            n_count = r_count + COUNT_W'(1);
            if (!r_text_ended) begin
                if (i_byte == CH_NUL || i_byte == CH_COMMA) begin
                    if (r_inside) begin
                        n_acc1   = fin_acc1;
                        n_acc2   = fin_acc2;
                        n_inside = 1'b0;
                        n_neg    = 1'b0;
                        n_phase  = NUM_SKIP;
                        if (r_field != FIELD_REST) begin
                            n_field = r_field + 2'd1;
                        end
                    end
                    n_text_ended = (i_byte == CH_NUL);
                end else begin
                    n_inside = 1'b1;
                    if (!r_inside && r_field == FIELD_CMD) begin
                        n_letter = i_byte;
                    end
                    if (r_field == FIELD_ARG1 || r_field == FIELD_ARG2) begin
                        n_phase = num_out.phase;
                        n_neg   = num_out.neg;
                        if (r_field == FIELD_ARG1) begin
                            n_acc1 = num_out.acc;
                        end else begin
                            n_acc2 = num_out.acc;
                        end
                    end else begin
                        n_phase = num_in.phase;
                        n_neg   = num_in.neg;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_count      <= '0;
            r_field      <= FIELD_CMD;
            r_inside     <= 1'b0;
            r_text_ended <= 1'b0;
            r_letter     <= CH_NUL;
            r_phase      <= NUM_SKIP;
            r_neg        <= 1'b0;
            r_acc1       <= '0;
            r_acc2       <= '0;
        end else begin
            r_frame_open <= n_frame_open;
            r_count      <= n_count;
            r_field      <= n_field;
            r_inside     <= n_inside;
            r_text_ended <= n_text_ended;
            r_letter     <= n_letter;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_acc1       <= n_acc1;
            r_acc2       <= n_acc2;
        end
    end

endmodule
`default_nettype wire

// File: rtl/facp_checker.sv
// Port-level assertions for the command parser and their binding to the top level.
`default_nettype none
module facp_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [3:0]         i_code,
    input wire logic signed [15:0] i_first,
    input wire logic signed [15:0] i_second
);
    import facp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code)
            && $stable(i_first) && $stable(i_second))
        else $error("command word changed while stalled");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_code <= CMD_TIMEOUT)
        else $error("command code out of range");

    a_no_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_code == CMD_INVALID || i_code == CMD_PING || i_code == CMD_STOP)
            |-> i_first == 16'sd0 && i_second == 16'sd0)
        else $error("argument on a command without arguments");

    a_second_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_code != CMD_MOVE |-> i_second == 16'sd0)
        else $error("second argument on a command other than move");

    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_out_valid)
        else $error("command word shown right after reset");

endmodule

bind framed_ascii_command_parser_core facp_checker u_facp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_cmd.valid),
    .i_out_ready (o_cmd.ready),
    .i_code      (o_cmd.command_code),
    .i_first     (o_cmd.first_value),
    .i_second    (o_cmd.second_value)
);
`default_nettype wire
